### rtl/core/caf_pkg.sv
package caf_pkg;

	localparam int CW = 34;
	localparam int ATAN_N = 24;
	localparam int ATAN_IW = 5;
	localparam int QDEPTH = 2;

	localparam logic signed [CW-1:0] PI_Q30 = 34'sd3373259426;
	localparam logic signed [CW-1:0] HALF_PI_Q30 = 34'sd1686629713;
	localparam logic signed [CW-1:0] CORDIC_GAIN_Q30 = 34'sd652032874;
	localparam logic signed [31:0] COS_FLOOR_Q30 = 32'sd16777216;
	localparam logic [31:0] DIV_SEED = 32'd8388608;
	localparam logic [15:0] ALPHA_ONE = 16'd32768;
	localparam logic signed [47:0] Q13_MAX = 48'sd25736;
	localparam logic [15:0] GAIN_RESET = 16'd3277;
	localparam logic [4:0] SQ_LAST = 5'd23;
	localparam logic [4:0] DV_LAST = 5'd30;

	localparam logic [31:0] ATAN_TAB [ATAN_N] = '{
		32'd843314857, 32'd497837829, 32'd263043837, 32'd133525159,
		32'd67021687,  32'd33543516,  32'd16775851,  32'd8388437,
		32'd4194283,   32'd2097149,   32'd1048576,   32'd524288,
		32'd262144,    32'd131072,    32'd65536,     32'd32768,
		32'd16384,     32'd8192,      32'd4096,      32'd2048,
		32'd1024,      32'd512,       32'd256,       32'd128
	};

	typedef struct packed {
		logic signed [15:0] gyro_roll_rate;
		logic signed [15:0] gyro_pitch_rate;
		logic signed [15:0] gyro_yaw_rate;
		logic signed [15:0] accel_x;
		logic signed [15:0] accel_y;
		logic signed [15:0] accel_z;
		logic [15:0] sample_period;
	} in_item_t;

	typedef struct packed {
		logic signed [15:0] roll_angle;
		logic signed [15:0] pitch_angle;
		logic signed [15:0] yaw_angle;
	} out_item_t;

	typedef struct packed {
		in_item_t item;
		logic [31:0] sum;
		logic [30:0] tilt;
		logic sat;
		logic zero;
	} qent_t;

	typedef struct packed {
		logic start;
		logic vec;
	} cor_ctl_t;

	typedef enum logic [4:0] {
		B_IDLE, B_RT1, B_CV1_GO, B_CV1_W, B_RT2, B_CV2_GO, B_CV2_W,
		B_CR1_GO, B_CR1_W, B_CR2_GO, B_CR2_W,
		B_M1, B_M2, B_M3, B_M4, B_DIV, B_M5, B_M6, B_M7,
		B_B1, B_B2, B_B3, B_B4, B_B5, B_B6, B_B7, B_DONE
	} bk_state_t;

	function automatic logic signed [15:0] to_q13(input logic signed [47:0] v);
		logic signed [47:0] t;
		t = (v + 48'sd65536) >>> 17;
		if (t > Q13_MAX) begin
			t = Q13_MAX;
		end else if (t < -Q13_MAX) begin
			t = -Q13_MAX;
		end
		to_q13 = t[15:0];
	endfunction

endpackage

### rtl/core/complementary_attitude_filter.sv
// channel   direction  handshake            payload
// in        input      in_valid/in_ready    in_item (caf_pkg::in_item_t)
// out       output     out_valid/out_ready  out_item (caf_pkg::out_item_t)
// cfg       input      cfg_we               cfg_data (blend gain, Q1.15)
//
// one item at a time in the back end, which makes four passes of the shared cordic
// and runs two square roots and a divide for each item
// the second square root is skipped when the pitch ratio saturates
// a front register and a two-item queue keep accepting while the back end works
// a finished result waits in the output register; the next item runs, but holds in B_DONE until it is taken
// reset clears the estimates to zero and the blend gain to 3277; no clearing pass
module complementary_attitude_filter #(
	parameter int GRAVITY_COUNTS = 10042,
	parameter int CORDIC_STEPS = 16
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_we,
	input  logic [15:0]        cfg_data,
	input  logic               in_valid,
	output logic               in_ready,
	input  caf_pkg::in_item_t  in_item,
	output logic               out_valid,
	input  logic               out_ready,
	output caf_pkg::out_item_t out_item
);
	import caf_pkg::*;

	logic [15:0] blend_gain_q;
	logic fe_valid, fe_ready, qe_valid, qe_ready;
	qent_t fe_ent, qe_ent;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			blend_gain_q <= GAIN_RESET;
		end else if (cfg_we) begin
			blend_gain_q <= cfg_data;
		end
	end

	caf_front #(.GRAVITY(GRAVITY_COUNTS)) u_front (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready), .in_item(in_item),
		.ent_valid(fe_valid), .ent_ready(fe_ready), .ent(fe_ent)
	);

	caf_queue u_queue (
		.clk(clk), .arst_n(arst_n),
		.push_valid(fe_valid), .push_ready(fe_ready), .push_ent(fe_ent),
		.pop_valid(qe_valid), .pop_ready(qe_ready), .pop_ent(qe_ent)
	);

	caf_back #(.STEPS(CORDIC_STEPS)) u_back (
		.clk(clk), .arst_n(arst_n), .blend_gain(blend_gain_q),
		.ent_valid(qe_valid), .ent_ready(qe_ready), .ent(qe_ent),
		.out_valid(out_valid), .out_ready(out_ready), .out_item(out_item)
	);

endmodule

### rtl/core/caf_front.sv
module caf_front #(
	parameter int GRAVITY = 10042
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_ready,
	input  caf_pkg::in_item_t in_item,
	output logic             ent_valid,
	input  logic             ent_ready,
	output caf_pkg::qent_t   ent
);
	import caf_pkg::*;

	localparam logic signed [16:0] G_S = 17'(GRAVITY);
	localparam logic [30:0] G_SQ = 31'(GRAVITY * GRAVITY);

	logic fr_valid_q;
	qent_t fr_ent_q, cls;
	logic signed [31:0] ax32, az32, axsq, azsq;
	logic signed [16:0] ax17;

	assign ax32 = 32'(in_item.accel_x);
	assign az32 = 32'(in_item.accel_z);
	assign ax17 = 17'(in_item.accel_x);
	assign axsq = ax32 * ax32;
	assign azsq = az32 * az32;

	always_comb begin
		cls.item = in_item;
		cls.sum = 32'(axsq) + 32'(azsq);
		cls.sat = (ax17 >= G_S) || (ax17 <= -G_S);
		cls.tilt = cls.sat ? 31'd0 : (G_SQ - axsq[30:0]);
		cls.zero = (cls.sum == 32'd0) && (in_item.accel_y == 16'sd0);
	end

	assign in_ready = !fr_valid_q || ent_ready;
	assign ent_valid = fr_valid_q;
	assign ent = fr_ent_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fr_valid_q <= 1'b0;
		end else if (in_valid && in_ready) begin
			fr_valid_q <= 1'b1;
		end else if (ent_ready) begin
			fr_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			fr_ent_q <= cls;
		end
	end

endmodule

### rtl/core/caf_queue.sv
module caf_queue (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push_valid,
	output logic           push_ready,
	input  caf_pkg::qent_t push_ent,
	output logic           pop_valid,
	input  logic           pop_ready,
	output caf_pkg::qent_t pop_ent
);
	import caf_pkg::*;

	localparam int PW = $clog2(QDEPTH);

	qent_t mem [QDEPTH];
	logic [PW-1:0] wr_ptr_q, rd_ptr_q;
	logic [PW:0] cnt_q;
	logic push, pop;

	assign push_ready = cnt_q != (PW+1)'(QDEPTH);
	assign pop_valid = cnt_q != '0;
	assign push = push_valid && push_ready;
	assign pop = pop_valid && pop_ready;
	assign pop_ent = mem[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PW'(QDEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PW'(QDEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem[wr_ptr_q] <= push_ent;
		end
	end

endmodule

### rtl/core/caf_cordic.sv
module caf_cordic #(
	parameter int STEPS = 16
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  caf_pkg::cor_ctl_t             ctl,
	input  logic signed [caf_pkg::CW-1:0] x0,
	input  logic signed [caf_pkg::CW-1:0] y0,
	input  logic signed [caf_pkg::CW-1:0] z0,
	output logic                          busy,
	output logic                          done,
	output logic signed [caf_pkg::CW-1:0] x,
	output logic signed [caf_pkg::CW-1:0] y,
	output logic signed [caf_pkg::CW-1:0] z
);
	import caf_pkg::*;

	localparam int CNT_W = $clog2(STEPS);

	logic [CNT_W-1:0] cnt_q;
	logic busy_q, done_q, vec_q, last, up;
	logic signed [CW-1:0] x_q, y_q, z_q, dx, dy, da;

	assign dx = x_q >>> cnt_q;
	assign dy = y_q >>> cnt_q;
	assign da = CW'($signed({1'b0, ATAN_TAB[ATAN_IW'(cnt_q)]}));
	// vectoring drives y to zero, rotation drives z to zero
	assign up = vec_q ? !y_q[CW-1] : z_q[CW-1];
	assign last = cnt_q == CNT_W'(STEPS - 1);

	assign busy = busy_q;
	assign done = done_q;
	assign x = x_q;
	assign y = y_q;
	assign z = z_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q <= '0;
		end else begin
			done_q <= busy_q && last;
			if (ctl.start) begin
				busy_q <= 1'b1;
				cnt_q <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (last) begin
					busy_q <= 1'b0;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.start) begin
			vec_q <= ctl.vec;
			x_q <= x0;
			y_q <= y0;
			z_q <= z0;
		end else if (busy_q) begin
			if (up) begin
				x_q <= x_q + dy;
				y_q <= y_q - dx;
				z_q <= z_q + da;
			end else begin
				x_q <= x_q - dy;
				y_q <= y_q + dx;
				z_q <= z_q - da;
			end
		end
	end

endmodule

### rtl/core/caf_back.sv
module caf_back #(
	parameter int STEPS = 16
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic [15:0]       blend_gain,
	input  logic              ent_valid,
	output logic              ent_ready,
	input  caf_pkg::qent_t    ent,
	output logic              out_valid,
	input  logic              out_ready,
	output caf_pkg::out_item_t out_item
);
	import caf_pkg::*;

	bk_state_t state_q, state_d;
	qent_t e_q;

	logic [47:0] rad_q;
	logic [24:0] rem_q;
	logic [23:0] root_q;
	logic [4:0] sq_cnt_q;
	logic [26:0] remsh, trial;
	logic sq_ge;

	logic [31:0] dv_rem_q, dv_d_q, dv_sh;
	logic [30:0] dv_quo_q;
	logic dv_neg_q, dv_ge;
	logic [4:0] dv_cnt_q;
	logic signed [31:0] sec_c;

	cor_ctl_t cor_ctl;
	logic cor_busy, cor_done;
	logic signed [CW-1:0] cx0, cy0, cz0, cx, cy, cz;
	logic signed [CW-1:0] ang, fang, rs, rc;
	logic signed [15:0] rot_src;
	logic fneg, rot_neg_q;

	logic signed [CW-1:0] phi_q, theta_q;
	logic signed [31:0] sr_q, cr_q, sp_q, cp_q;
	logic signed [63:0] acc_q, prod_a, acc_sum, acc_dif;
	logic signed [31:0] ma_a, ma_b;
	logic signed [27:0] w_q, pr_q;
	logic signed [31:0] sec_q, tn_q;
	logic signed [33:0] rr_q, yr_q;
	logic signed [39:0] mb_a, pred_r_q, pred_p_q, base, pred;
	logic signed [17:0] mb_b;
	logic signed [57:0] prod_b, bacc_q, bsum;
	logic signed [15:0] roll_q, pitch_q, yaw_q, nroll_q, npitch_q, nyaw_q;
	logic [15:0] alpha, alpha_inv;
	logic out_valid_q, load;
	out_item_t out_item_q;

	caf_cordic #(.STEPS(STEPS)) u_cordic (
		.clk(clk), .arst_n(arst_n), .ctl(cor_ctl),
		.x0(cx0), .y0(cy0), .z0(cz0),
		.busy(cor_busy), .done(cor_done), .x(cx), .y(cy), .z(cz)
	);

	assign alpha = (blend_gain > ALPHA_ONE) ? ALPHA_ONE : blend_gain;
	assign alpha_inv = ALPHA_ONE - alpha;

	// square root, one result bit per cycle
	assign remsh = {rem_q, rad_q[47:46]};
	assign trial = {1'b0, root_q, 2'b01};
	assign sq_ge = remsh >= trial;

	// secant divide, one quotient bit per cycle
	assign dv_sh = {dv_rem_q[30:0], 1'b0};
	assign dv_ge = dv_sh >= dv_d_q;
	assign sec_c = dv_neg_q ? -$signed({1'b0, dv_quo_q}) : $signed({1'b0, dv_quo_q});

	always_comb begin
		rot_src = (state_q == B_CR2_GO) ? pitch_q : roll_q;
		ang = CW'($signed({rot_src, 17'd0}));
		fneg = 1'b0;
		priority if (ang > HALF_PI_Q30) begin
			fang = ang - PI_Q30;
			fneg = 1'b1;
		end else if (ang < -HALF_PI_Q30) begin
			fang = ang + PI_Q30;
			fneg = 1'b1;
		end else begin
			fang = ang;
		end
	end

	assign rs = rot_neg_q ? -cy : cy;
	assign rc = rot_neg_q ? -cx : cx;

	assign prod_a = ma_a * ma_b;
	assign prod_b = mb_a * mb_b;
	assign acc_sum = acc_q + prod_a;
	assign acc_dif = acc_q - prod_a;
	assign bsum = bacc_q + prod_b;
	assign load = (state_q == B_DONE) && (!out_valid_q || out_ready);

	always_comb begin
		base = 40'($signed({roll_q, 17'd0}));
		unique case (state_q)
			B_B2: base = 40'($signed({pitch_q, 17'd0}));
			B_B3: base = 40'($signed({yaw_q, 17'd0}));
			default: base = 40'($signed({roll_q, 17'd0}));
		endcase
		pred = base + $signed(prod_b[49:10]);
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			B_IDLE: if (ent_valid) state_d = B_RT1;
			B_RT1: if (sq_cnt_q == SQ_LAST) state_d = B_CV1_GO;
			B_CV1_GO: state_d = B_CV1_W;
			B_CV1_W: if (cor_done) state_d = e_q.sat ? B_CV2_GO : B_RT2;
			B_RT2: if (sq_cnt_q == SQ_LAST) state_d = B_CV2_GO;
			B_CV2_GO: state_d = B_CV2_W;
			B_CV2_W: if (cor_done) state_d = B_CR1_GO;
			B_CR1_GO: state_d = B_CR1_W;
			B_CR1_W: if (cor_done) state_d = B_CR2_GO;
			B_CR2_GO: state_d = B_CR2_W;
			B_CR2_W: if (cor_done) state_d = B_M1;
			B_M1: state_d = B_M2;
			B_M2: state_d = B_M3;
			B_M3: state_d = B_M4;
			B_M4: state_d = B_DIV;
			B_DIV: if (dv_cnt_q == DV_LAST) state_d = B_M5;
			B_M5: state_d = B_M6;
			B_M6: state_d = B_M7;
			B_M7: state_d = B_B1;
			B_B1: state_d = B_B2;
			B_B2: state_d = B_B3;
			B_B3: state_d = B_B4;
			B_B4: state_d = B_B5;
			B_B5: state_d = B_B6;
			B_B6: state_d = B_B7;
			B_B7: state_d = B_DONE;
			B_DONE: if (load) state_d = B_IDLE;
			default: state_d = B_IDLE;
		endcase
	end

	always_comb begin
		ent_ready = 1'b0;
		cor_ctl = '0;
		cx0 = '0;
		cy0 = '0;
		cz0 = '0;
		ma_a = '0;
		ma_b = '0;
		mb_a = '0;
		mb_b = '0;
		unique case (state_q)
			B_IDLE: ent_ready = 1'b1;
			B_CV1_GO: begin
				cor_ctl = '{start: 1'b1, vec: 1'b1};
				cx0 = CW'(root_q);
				cy0 = CW'(e_q.item.accel_y) <<< 4;
			end
			B_CV2_GO: begin
				cor_ctl = '{start: 1'b1, vec: 1'b1};
				cx0 = e_q.sat ? '0 : CW'(root_q);
				cy0 = e_q.sat ? CW'(e_q.item.accel_x) : (CW'(e_q.item.accel_x) <<< 8);
			end
			B_CR1_GO, B_CR2_GO: begin
				cor_ctl = '{start: 1'b1, vec: 1'b0};
				cx0 = CORDIC_GAIN_Q30;
				cz0 = fang;
			end
			B_M1: begin
				ma_a = sr_q;
				ma_b = 32'(e_q.item.gyro_pitch_rate);
			end
			B_M2: begin
				ma_a = cr_q;
				ma_b = 32'(e_q.item.gyro_yaw_rate);
			end
			B_M3: begin
				ma_a = cr_q;
				ma_b = 32'(e_q.item.gyro_pitch_rate);
			end
			B_M4: begin
				ma_a = sr_q;
				ma_b = 32'(e_q.item.gyro_yaw_rate);
			end
			B_M5: begin
				ma_a = sp_q;
				ma_b = sec_c;
			end
			B_M6: begin
				ma_a = 32'(w_q);
				ma_b = tn_q;
			end
			B_M7: begin
				ma_a = 32'(w_q);
				ma_b = sec_q;
			end
			B_B1: begin
				mb_a = 40'(rr_q);
				mb_b = $signed({2'b00, e_q.item.sample_period});
			end
			B_B2: begin
				mb_a = 40'(pr_q);
				mb_b = $signed({2'b00, e_q.item.sample_period});
			end
			B_B3: begin
				mb_a = 40'(yr_q);
				mb_b = $signed({2'b00, e_q.item.sample_period});
			end
			B_B4: begin
				mb_a = 40'(phi_q);
				mb_b = $signed({2'b00, alpha});
			end
			B_B5: begin
				mb_a = pred_r_q;
				mb_b = $signed({2'b00, alpha_inv});
			end
			B_B6: begin
				mb_a = 40'(theta_q);
				mb_b = $signed({2'b00, alpha});
			end
			B_B7: begin
				mb_a = pred_p_q;
				mb_b = $signed({2'b00, alpha_inv});
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= B_IDLE;
			out_valid_q <= 1'b0;
			roll_q <= '0;
			pitch_q <= '0;
			yaw_q <= '0;
		end else begin
			state_q <= state_d;
			if (load) begin
				out_valid_q <= 1'b1;
				roll_q <= nroll_q;
				pitch_q <= npitch_q;
				yaw_q <= nyaw_q;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			B_IDLE: begin
				e_q <= ent;
				rad_q <= {8'd0, ent.sum, 8'd0};
				rem_q <= '0;
				root_q <= '0;
				sq_cnt_q <= '0;
			end
			B_RT1, B_RT2: begin
				rad_q <= {rad_q[45:0], 2'b00};
				rem_q <= sq_ge ? 25'(remsh - trial) : remsh[24:0];
				root_q <= {root_q[22:0], sq_ge};
				sq_cnt_q <= sq_cnt_q + 5'd1;
			end
			B_CV1_W: begin
				if (cor_done) begin
					phi_q <= e_q.zero ? '0 : cz;
				end
				rad_q <= {1'b0, e_q.tilt, 16'd0};
				rem_q <= '0;
				root_q <= '0;
				sq_cnt_q <= '0;
			end
			B_CV2_W: if (cor_done) theta_q <= cz;
			B_CR1_GO, B_CR2_GO: rot_neg_q <= fneg;
			B_CR1_W: begin
				if (cor_done) begin
					sr_q <= rs[31:0];
					cr_q <= rc[31:0];
				end
			end
			B_CR2_W: begin
				if (cor_done) begin
					sp_q <= rs[31:0];
					cp_q <= rc[31:0];
				end
			end
			B_M1, B_M3: acc_q <= prod_a;
			B_M2: w_q <= $signed(acc_sum[47:20]);
			B_M4: begin
				pr_q <= $signed(acc_dif[47:20]);
				dv_rem_q <= DIV_SEED;
				dv_quo_q <= '0;
				dv_cnt_q <= '0;
				dv_neg_q <= cp_q[31];
				// secant saturates near vertical
				priority if (!cp_q[31] && cp_q < COS_FLOOR_Q30) begin
					dv_d_q <= 32'(COS_FLOOR_Q30);
				end else if (cp_q[31] && cp_q > -COS_FLOOR_Q30) begin
					dv_d_q <= 32'(COS_FLOOR_Q30);
				end else begin
					dv_d_q <= cp_q[31] ? 32'(-cp_q) : 32'(cp_q);
				end
			end
			B_DIV: begin
				dv_rem_q <= dv_ge ? dv_sh - dv_d_q : dv_sh;
				dv_quo_q <= {dv_quo_q[29:0], dv_ge};
				dv_cnt_q <= dv_cnt_q + 5'd1;
			end
			B_M5: begin
				sec_q <= sec_c;
				tn_q <= $signed(prod_a[61:30]);
			end
			B_M6: rr_q <= $signed({e_q.item.gyro_roll_rate, 10'd0}) + $signed(prod_a[57:24]);
			B_M7: yr_q <= $signed(prod_a[57:24]);
			B_B1: pred_r_q <= pred;
			B_B2: pred_p_q <= pred;
			B_B3: nyaw_q <= to_q13(48'(pred));
			B_B4, B_B6: bacc_q <= prod_b;
			B_B5: nroll_q <= to_q13(48'($signed(bsum[57:15])));
			B_B7: npitch_q <= to_q13(48'($signed(bsum[57:15])));
			B_DONE: begin
				if (load) begin
					out_item_q <= '{roll_angle: nroll_q, pitch_angle: npitch_q,
						yaw_angle: nyaw_q};
				end
			end
			default: ;
		endcase
	end

	assign out_valid = out_valid_q;
	assign out_item = out_item_q;

`ifndef SYNTH
	a_est_range: assert property (@(posedge clk) disable iff (!arst_n)
		(roll_q <= 16'sd25736) && (roll_q >= -16'sd25736) &&
		(pitch_q <= 16'sd25736) && (pitch_q >= -16'sd25736) &&
		(yaw_q <= 16'sd25736) && (yaw_q >= -16'sd25736))
		else $error("estimate out of range");
	a_cor_start: assert property (@(posedge clk) disable iff (!arst_n)
		cor_ctl.start |-> !cor_busy)
		else $error("cordic started while busy");
	a_cor_done: assert property (@(posedge clk) disable iff (!arst_n)
		cor_done |-> (state_q == B_CV1_W || state_q == B_CV2_W ||
			state_q == B_CR1_W || state_q == B_CR2_W))
		else $error("cordic done outside a wait state");
	a_div_floor: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == B_DIV) |-> (dv_d_q >= 32'(COS_FLOOR_Q30)))
		else $error("secant divisor below floor");
`endif

endmodule

### bench/tb_complementary_attitude_filter.sv
module tb_complementary_attitude_filter;
	timeunit 1ns;
	timeprecision 1ps;
	import caf_pkg::*;

	localparam int GRAV = 10042;
	localparam int STEPS = 16;
	localparam longint PI30 = 64'sd3373259426;
	localparam longint HPI30 = 64'sd1686629713;
	localparam longint GAIN30 = 64'sd652032874;
	localparam longint COSMIN = 64'sd16777216;
	localparam int PI13 = 25736;
	localparam int ONE = 32768;
	localparam int N_RAND = 1800;

	logic clk;
	logic arst_n;
	logic cfg_we;
	logic [15:0] cfg_data;
	logic in_valid;
	logic in_ready;
	in_item_t in_item;
	logic out_valid;
	logic out_ready;
	out_item_t out_item;

	complementary_attitude_filter dut (
		.clk(clk), .arst_n(arst_n), .cfg_we(cfg_we), .cfg_data(cfg_data),
		.in_valid(in_valid), .in_ready(in_ready), .in_item(in_item),
		.out_valid(out_valid), .out_ready(out_ready), .out_item(out_item)
	);

	function automatic longint atan_entry(int i);
		longint acc;
		longint term;
		int k;
		int m;
		acc = 0;
		if (i == 0) return 64'sd843314857;
		if (i >= 60) return 0;
		for (k = 0; i * (2 * k + 1) <= 60; k++) begin
			m = 2 * k + 1;
			term = longint'((64'd1 << (60 - i * m)) / m);
			acc = (k % 2) ? acc - term : acc + term;
		end
		return (acc + (64'sd1 << 29)) >>> 30;
	endfunction

	function automatic longint root64(longint unsigned v);
		longint unsigned res;
		longint unsigned b;
		res = 0;
		b = 64'd1 << 62;
		while (b > v) b >>= 2;
		while (b != 0) begin
			if (v >= res + b) begin
				v -= res + b;
				res = (res >> 1) + b;
			end else begin
				res >>= 1;
			end
			b >>= 2;
		end
		return longint'(res);
	endfunction

	function automatic longint angle_of(longint x, longint y);
		longint z;
		longint dx;
		longint dy;
		z = 0;
		if (x == 0 && y == 0) return 0;
		for (int i = 0; i < STEPS; i++) begin
			dx = x >>> i;
			dy = y >>> i;
			if (y >= 0) begin
				x += dy; y -= dx; z += atan_entry(i);
			end else begin
				x -= dy; y += dx; z -= atan_entry(i);
			end
		end
		return z;
	endfunction

	task automatic sin_cos(input longint a, output longint s, output longint c);
		longint x;
		longint y;
		longint dx;
		longint dy;
		bit flip;
		x = GAIN30;
		y = 0;
		flip = 0;
		if (a > HPI30) begin
			a -= PI30; flip = 1;
		end else if (a < -HPI30) begin
			a += PI30; flip = 1;
		end
		for (int i = 0; i < STEPS; i++) begin
			dx = x >>> i;
			dy = y >>> i;
			if (a >= 0) begin
				x -= dy; y += dx; a -= atan_entry(i);
			end else begin
				x += dy; y -= dx; a += atan_entry(i);
			end
		end
		s = flip ? -y : y;
		c = flip ? -x : x;
	endtask

	function automatic logic signed [15:0] round_clamp(longint v);
		longint t;
		t = (v + 65536) >>> 17;
		if (t > PI13) t = PI13;
		if (t < -PI13) t = -PI13;
		return t[15:0];
	endfunction

	class attitude_board;
		logic [15:0] gain;
		logic signed [15:0] roll_st, pitch_st, yaw_st;
		out_item_t pending[$];
		int errors;
		int checked;

		function new();
			gain = 16'd3277;
			roll_st = 0; pitch_st = 0; yaw_st = 0;
			errors = 0;
			checked = 0;
		endfunction

		task note_input(in_item_t it);
			longint p, q, r, ax, ay, az, dt;
			longint phi, theta, tx, ty, sp, cp, st, ct, ce, sec, tn, w, rr, pr, yr;
			longint pred_r, pred_p, pred_y, al;
			longint unsigned sum;
			out_item_t res;
			p = it.gyro_roll_rate; q = it.gyro_pitch_rate; r = it.gyro_yaw_rate;
			ax = it.accel_x; ay = it.accel_y; az = it.accel_z;
			dt = longint'({48'd0, it.sample_period});
			sum = longint'(ax * ax) + longint'(az * az);
			phi = angle_of(root64(sum << 8), ay * 16);
			if (ax >= GRAV || ax <= -GRAV) begin
				tx = 0; ty = ax;
			end else begin
				tx = root64(longint'(GRAV * GRAV - ax * ax) << 16);
				ty = ax * 256;
			end
			theta = angle_of(tx, ty);
			sin_cos(longint'(roll_st) * 131072, sp, cp);
			sin_cos(longint'(pitch_st) * 131072, st, ct);
			w = (sp * q + cp * r) >>> 20;
			pr = (cp * q - sp * r) >>> 20;
			ce = ct;
			if (ce >= 0 && ce < COSMIN) ce = COSMIN;
			else if (ce < 0 && ce > -COSMIN) ce = -COSMIN;
			sec = (64'sd1 << 54) / ce;
			tn = (st * sec) >>> 30;
			rr = p * 1024 + ((w * tn) >>> 24);
			yr = (w * sec) >>> 24;
			pred_r = longint'(roll_st) * 131072 + ((rr * dt) >>> 10);
			pred_p = longint'(pitch_st) * 131072 + ((pr * dt) >>> 10);
			pred_y = longint'(yaw_st) * 131072 + ((yr * dt) >>> 10);
			al = gain;
			if (al > ONE) al = ONE;
			roll_st = round_clamp((al * phi + (ONE - al) * pred_r) >>> 15);
			pitch_st = round_clamp((al * theta + (ONE - al) * pred_p) >>> 15);
			yaw_st = round_clamp(pred_y);
			res.roll_angle = roll_st;
			res.pitch_angle = pitch_st;
			res.yaw_angle = yaw_st;
			pending.push_back(res);
		endtask

		function void check_result(out_item_t got);
			out_item_t exp_item;
			if (pending.size() == 0) begin
				$display("%0t: unexpected result %h", $time, got);
				errors++;
				return;
			end
			exp_item = pending.pop_front();
			checked++;
			if (got.roll_angle !== exp_item.roll_angle) begin
				$display("%0t: roll expected %0d actual %0d", $time,
					exp_item.roll_angle, got.roll_angle);
				errors++;
			end
			if (got.pitch_angle !== exp_item.pitch_angle) begin
				$display("%0t: pitch expected %0d actual %0d", $time,
					exp_item.pitch_angle, got.pitch_angle);
				errors++;
			end
			if (got.yaw_angle !== exp_item.yaw_angle) begin
				$display("%0t: yaw expected %0d actual %0d", $time,
					exp_item.yaw_angle, got.yaw_angle);
				errors++;
			end
		endfunction
	endclass

	attitude_board board;
	int sent;

	initial begin
		clk = 0;
		forever #6 clk = ~clk;
	end

	function automatic int gap_len();
		int k;
		k = $urandom_range(0, 99);
		if (k < 55) return 0;
		if (k < 92) return $urandom_range(1, 4);
		return $urandom_range(20, 150);
	endfunction

	task automatic send_item(in_item_t it);
		repeat (gap_len()) @(negedge clk);
		in_item = it;
		in_valid = 1'b1;
		do @(posedge clk); while (!in_ready);
		board.note_input(it);
		sent++;
		@(negedge clk);
		in_valid = 1'b0;
		in_item = in_item_t'(112'({$urandom, $urandom, $urandom, $urandom}));
	endtask

	task automatic set_gain(logic [15:0] v);
		while (board.pending.size() != 0) @(negedge clk);
		repeat (200) @(negedge clk);
		cfg_data <= v;
		cfg_we <= 1'b1;
		@(negedge clk);
		cfg_we <= 1'b0;
		board.gain = v;
	endtask

	function automatic logic [15:0] pick16();
		case ($urandom_range(0, 5))
			0: return 16'h8000;
			1: return 16'h7fff;
			2: return 16'(signed'($urandom_range(0, 40)) - 20);
			default: return 16'($urandom);
		endcase
	endfunction

	function automatic in_item_t rand_item();
		in_item_t it;
		int k;
		k = $urandom_range(0, 9);
		it.gyro_roll_rate = (k < 7) ? 16'(signed'($urandom_range(0, 4000)) - 2000) : pick16();
		it.gyro_pitch_rate = (k < 7) ? 16'(signed'($urandom_range(0, 4000)) - 2000) : pick16();
		it.gyro_yaw_rate = (k < 7) ? 16'(signed'($urandom_range(0, 4000)) - 2000) : pick16();
		if (k < 6) begin
			it.accel_x = 16'(signed'($urandom_range(0, 22000)) - 11000);
			it.accel_y = 16'(signed'($urandom_range(0, 6000)) - 3000);
			it.accel_z = 16'(signed'($urandom_range(0, 22000)) - 11000);
		end else begin
			it.accel_x = pick16();
			it.accel_y = pick16();
			it.accel_z = pick16();
		end
		it.sample_period = (k < 8) ? 16'($urandom_range(0, 4000)) : 16'($urandom);
		return it;
	endfunction

	initial begin
		in_item_t it;
		logic [15:0] gains[6];
		int phase_len;
		board = new();
		sent = 0;
		arst_n = 0;
		cfg_we = 0;
		cfg_data = 0;
		in_valid = 0;
		in_item = '0;
		repeat (4) @(negedge clk);
		arst_n = 1;
		@(negedge clk);
		// directed items
		send_item('0);
		send_item('{16'h7fff, 16'h7fff, 16'h7fff, 16'h7fff, 16'h7fff, 16'h7fff, 16'hffff});
		send_item('{16'h8000, 16'h8000, 16'h8000, 16'h8000, 16'h8000, 16'h8000, 16'hffff});
		send_item('{16'd100, -16'sd50, 16'd30, 16'sd0, 16'sd0, 16'sd0, 16'd1000});
		send_item('{16'd100, 16'd200, 16'd300, 16'sd10042, 16'sd5, 16'sd0, 16'd0});
		send_item('{16'd0, 16'd0, 16'd0, -16'sd10042, 16'sd0, 16'sd300, 16'd500});
		send_item('{16'd0, 16'd0, 16'd0, 16'sd10041, 16'sd0, 16'sd0, 16'd500});
		set_gain(16'd32768);
		send_item('{16'd0, 16'd0, 16'd0, 16'sd10042, 16'sd0, 16'sd0, 16'd10});
		send_item('{16'd0, 16'd0, 16'd0, 16'sd10042, 16'sd0, 16'sd0, 16'd10});
		set_gain(16'd0);
		send_item('{16'h7fff, 16'h7fff, 16'h7fff, 16'sd0, 16'sd0, 16'sd10042, 16'hffff});
		send_item('{16'h7fff, 16'h8000, 16'h7fff, 16'sd0, 16'sd0, 16'sd10042, 16'hffff});
		set_gain(16'hffff);
		send_item('{16'd5, 16'd5, 16'd5, 16'sd0, 16'sd10042, 16'sd0, 16'd100});
		gains = '{16'd3277, 16'd0, 16'd32768, 16'hffff, 16'd16384, 16'd1000};
		for (int ph = 0; ph < 6; ph++) begin
			set_gain(ph < 5 ? gains[ph + 1] : 16'($urandom_range(0, 32768)));
			phase_len = N_RAND / 6;
			for (int n = 0; n < phase_len; n++) begin
				it = rand_item();
				send_item(it);
			end
		end
		while (board.pending.size() != 0) @(negedge clk);
		repeat (300) @(negedge clk);
		$display("sent %0d imu samples, checked %0d attitude results over 10 gain settings",
			sent, board.checked);
		if (board.errors == 0 && board.pending.size() == 0) begin
			$display("** complementary_attitude_filter: PASSED **");
		end else begin
			$display("** complementary_attitude_filter: FAILED **");
		end
		$finish;
	end

	initial begin
		out_ready = 0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if ($urandom_range(0, 80) == 0) begin
				out_ready <= 1'b0;
				repeat ($urandom_range(20, 200)) @(negedge clk);
				out_ready <= 1'b1;
			end else begin
				out_ready <= ($urandom_range(0, 3) != 0) || ($urandom_range(0, 60) == 0);
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready) board.check_result(out_item);
	end

	initial begin
		#100ms;
		$display("** complementary_attitude_filter: FAILED **");
		$finish;
	end
endmodule

### sim.f
rtl/core/caf_pkg.sv
rtl/core/caf_front.sv
rtl/core/caf_queue.sv
rtl/core/caf_cordic.sv
rtl/core/caf_back.sv
rtl/core/complementary_attitude_filter.sv
bench/tb_complementary_attitude_filter.sv
